// ===== rtl/ctf_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the complementary tilt filter.
package ctf_pkg;

    // CORDIC sizing: table length, iteration index, vector and angle widths
    localparam int unsigned CORDIC_TAB_LEN = 24;
    localparam int unsigned IDX_W          = 5;
    localparam int unsigned XY_W           = 34;
    localparam int unsigned Z_W            = 25;

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_A_W = 28;
    localparam int unsigned MUL_B_W = 27;
    localparam int unsigned PROD_W  = 55;

    // Angle constants in 2^-15 degree and 1/128 degree
    localparam logic signed [Z_W-1:0] PRE_ROT_ANGLE = 25'sd2949120;
    localparam logic signed [16:0]    ANGLE_LIMIT   = 17'sd23040;

    // Integration delta: divide by 256000 = 2^11 * 125, rounded half away from zero
    localparam logic [37:0] DELTA_HALF  = 38'd128000;
    localparam logic [25:0] RECIP_125   = 26'd34359738;
    localparam logic [25:0] DIVISOR_125 = 26'd125;

    // Blend weight full scale (Q16 one)
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BLEND_WEIGHT = 2'd0,
        CFG_GYRO_FS      = 2'd1,
        CFG_STEP_MS      = 2'd2
    } t_cfg_idx;

    // Datapath operation for one cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_GYFS,
        OP_GZFS,
        OP_STEP,
        OP_SCALE,
        OP_RECIP,
        OP_QUOT,
        OP_QMUL,
        OP_FIX,
        OP_PSUB,
        OP_ANGLE,
        OP_MULW,
        OP_MULA,
        OP_SUM,
        OP_STORE,
        OP_OUT
    } t_dp_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_GYFS,
        S_GZFS,
        S_STEP,
        S_SCALE,
        S_RECIP,
        S_QUOT,
        S_QMUL,
        S_FIX,
        S_PSUB,
        S_WAIT,
        S_MULW,
        S_MULA,
        S_SUM,
        S_STORE,
        S_OUT
    } t_ctf_state;

    // Commands from controller to datapath
    typedef struct packed {
        t_dp_op           op;
        logic             cordic_step;
        logic [IDX_W-1:0] cordic_idx;
    } t_ctf_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_ctf_sts;

    // Arctangent of 2^-i in 2^-15 degree
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd1474560;
            5'd1:    v = 25'sd870484;
            5'd2:    v = 25'sd459940;
            5'd3:    v = 25'sd233473;
            5'd4:    v = 25'sd117189;
            5'd5:    v = 25'sd58653;
            5'd6:    v = 25'sd29333;
            5'd7:    v = 25'sd14667;
            5'd8:    v = 25'sd7334;
            5'd9:    v = 25'sd3667;
            5'd10:   v = 25'sd1833;
            5'd11:   v = 25'sd917;
            5'd12:   v = 25'sd458;
            5'd13:   v = 25'sd229;
            5'd14:   v = 25'sd115;
            5'd15:   v = 25'sd57;
            5'd16:   v = 25'sd29;
            5'd17:   v = 25'sd14;
            5'd18:   v = 25'sd7;
            5'd19:   v = 25'sd4;
            5'd20:   v = 25'sd2;
            5'd21:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ctf_ctrl.sv =====
// Controller state machine: sequences the multiply chain, CORDIC iterations and output.
module ctf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output ctf_pkg::t_ctf_cmd o_cmd,
    input  ctf_pkg::t_ctf_sts i_sts
);

    localparam int EFF_STEPS = (CORDIC_STEPS > int'(ctf_pkg::CORDIC_TAB_LEN)) ?
                               int'(ctf_pkg::CORDIC_TAB_LEN) : CORDIC_STEPS;
    localparam logic [ctf_pkg::IDX_W-1:0] LAST_IDX = ctf_pkg::IDX_W'(EFF_STEPS - 1);

    ctf_pkg::t_ctf_state           r_state, n_state;
    logic [ctf_pkg::IDX_W-1:0]     r_iter, n_iter;
    logic                          r_crun, n_crun;
    logic                          ready;

    // State, iteration counter and CORDIC run flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctf_pkg::S_IDLE;
            r_iter  <= '0;
            r_crun  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_crun  <= n_crun;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        n_iter            = r_iter;
        n_crun            = r_crun;
        ready             = 1'b0;
        o_cmd.op          = ctf_pkg::OP_NONE;
        o_cmd.cordic_step = r_crun;
        o_cmd.cordic_idx  = r_iter;

        // Advance the CORDIC in parallel with the multiply chain
        if (r_crun) begin
            if (r_iter == LAST_IDX) begin
                n_crun = 1'b0;
            end else begin
                n_iter = r_iter + 1'b1;
            end
        end

        case (r_state)
            ctf_pkg::S_IDLE: begin
                ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = ctf_pkg::OP_LOAD;
                    n_crun   = 1'b1;
                    n_iter   = '0;
                    n_state  = ctf_pkg::S_GYFS;
                end
            end
            ctf_pkg::S_GYFS: begin
                o_cmd.op = ctf_pkg::OP_GYFS;
                n_state  = ctf_pkg::S_GZFS;
            end
            ctf_pkg::S_GZFS: begin
                o_cmd.op = ctf_pkg::OP_GZFS;
                n_state  = ctf_pkg::S_STEP;
            end
            ctf_pkg::S_STEP: begin
                o_cmd.op = ctf_pkg::OP_STEP;
                n_state  = ctf_pkg::S_SCALE;
            end
            ctf_pkg::S_SCALE: begin
                o_cmd.op = ctf_pkg::OP_SCALE;
                n_state  = ctf_pkg::S_RECIP;
            end
            ctf_pkg::S_RECIP: begin
                o_cmd.op = ctf_pkg::OP_RECIP;
                n_state  = ctf_pkg::S_QUOT;
            end
            ctf_pkg::S_QUOT: begin
                o_cmd.op = ctf_pkg::OP_QUOT;
                n_state  = ctf_pkg::S_QMUL;
            end
            ctf_pkg::S_QMUL: begin
                o_cmd.op = ctf_pkg::OP_QMUL;
                n_state  = ctf_pkg::S_FIX;
            end
            ctf_pkg::S_FIX: begin
                o_cmd.op = ctf_pkg::OP_FIX;
                n_state  = ctf_pkg::S_PSUB;
            end
            ctf_pkg::S_PSUB: begin
                o_cmd.op = ctf_pkg::OP_PSUB;
                n_state  = ctf_pkg::S_WAIT;
            end
            // Hold until the last CORDIC iteration is in, then round the angle
            ctf_pkg::S_WAIT: begin
                if (!r_crun) begin
                    o_cmd.op = ctf_pkg::OP_ANGLE;
                    n_state  = ctf_pkg::S_MULW;
                end
            end
            ctf_pkg::S_MULW: begin
                o_cmd.op = ctf_pkg::OP_MULW;
                n_state  = ctf_pkg::S_MULA;
            end
            ctf_pkg::S_MULA: begin
                o_cmd.op = ctf_pkg::OP_MULA;
                n_state  = ctf_pkg::S_SUM;
            end
            ctf_pkg::S_SUM: begin
                o_cmd.op = ctf_pkg::OP_SUM;
                n_state  = ctf_pkg::S_STORE;
            end
            ctf_pkg::S_STORE: begin
                o_cmd.op = ctf_pkg::OP_STORE;
                n_state  = ctf_pkg::S_OUT;
            end
            // Hand the result over once the output register is free
            ctf_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = ctf_pkg::OP_OUT;
                    n_state  = ctf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_s_tready = ready;

endmodule

// ===== rtl/ctf_dp.sv =====
// Datapath: iterative CORDIC, shared multiplier, rate scaling, blend and output register.
module ctf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctf_pkg::t_ctf_cmd i_cmd,
    output ctf_pkg::t_ctf_sts o_sts,
    input  logic              i_opcode,
    input  logic [15:0]       i_accel_x,
    input  logic [15:0]       i_accel_z,
    input  logic [15:0]       i_gyro_y,
    input  logic [15:0]       i_gyro_z,
    input  logic [16:0]       i_blend_weight,
    input  logic [10:0]       i_gyro_fs,
    input  logic [9:0]        i_step_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_tilt_angle,
    output logic [15:0]       o_accel_angle,
    output logic [18:0]       o_pitch_rate,
    output logic [18:0]       o_yaw_rate
);

    localparam int unsigned XY_W   = ctf_pkg::XY_W;
    localparam int unsigned Z_W    = ctf_pkg::Z_W;
    localparam int unsigned PROD_W = ctf_pkg::PROD_W;

    // Item registers
    logic                        r_op;
    logic signed [15:0]          r_gy, r_gz;
    logic                        r_zero;
    logic signed [XY_W-1:0]      r_x, r_y;
    logic signed [Z_W-1:0]       r_z;

    // Arithmetic registers
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [26:0]          r_gyfs;
    logic signed [18:0]          r_pitch, r_yaw;
    logic                        r_dneg;
    logic [24:0]                 r_dv;
    logic [18:0]                 r_q;
    logic signed [19:0]          r_delta;
    logic signed [19:0]          r_p;
    logic signed [15:0]          r_pa;
    logic signed [36:0]          r_acc;
    logic signed [37:0]          r_sum;
    logic signed [15:0]          r_fused;

    // Output register
    logic                        r_ovalid;
    logic signed [15:0]          r_out_tilt, r_out_pa;
    logic signed [18:0]          r_out_pitch, r_out_yaw;

    // Combinational helpers
    logic signed [ctf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ctf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           mul_p;
    logic [16:0]                        w_sat, w_acc;
    logic signed [XY_W-1:0]             ld_x, ld_y, ld_xn, ld_yn, ld_xr, ld_yr;
    logic signed [Z_W-1:0]              ld_z;
    logic signed [XY_W-1:0]             cr_dx, cr_dy;
    logic signed [Z_W-1:0]              cr_tab;
    logic signed [37:0]                 sc_p;
    logic [37:0]                        sc_mag, sc_sum;
    logic [25:0]                        fx_rem;
    logic [18:0]                        fx_q;
    logic signed [19:0]                 fx_delta;
    logic signed [Z_W-1:0]              an_r, an_s;
    logic signed [15:0]                 an_pa;
    logic signed [37:0]                 st_s;
    logic signed [15:0]                 st_b;

    // Round a rate product half away from zero after dividing by 256
    function automatic logic signed [18:0] rate_round(input logic signed [26:0] v);
        logic [26:0] mag;
        logic [26:0] sum;
        logic [18:0] q;
        mag = v[26] ? 27'(-v) : 27'(v);
        sum = mag + 27'd128;
        q   = sum[26:8];
        return v[26] ? -$signed(q) : $signed(q);
    endfunction

    // Saturate the weight and form the accel path weight
    assign w_sat = (i_blend_weight > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : i_blend_weight;
    assign w_acc = ctf_pkg::WEIGHT_ONE - w_sat;

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            ctf_pkg::OP_GYFS: begin
                mul_a = ctf_pkg::MUL_A_W'(r_gy);
                mul_b = {16'd0, i_gyro_fs};
            end
            ctf_pkg::OP_GZFS: begin
                mul_a = ctf_pkg::MUL_A_W'(r_gz);
                mul_b = {16'd0, i_gyro_fs};
            end
            ctf_pkg::OP_STEP: begin
                mul_a = ctf_pkg::MUL_A_W'(r_gyfs);
                mul_b = {17'd0, i_step_ms};
            end
            ctf_pkg::OP_RECIP: begin
                mul_a = {3'd0, r_dv};
                mul_b = {1'b0, ctf_pkg::RECIP_125};
            end
            ctf_pkg::OP_QMUL: begin
                mul_a = {9'd0, r_q};
                mul_b = {1'b0, ctf_pkg::DIVISOR_125};
            end
            ctf_pkg::OP_MULW: begin
                mul_a = ctf_pkg::MUL_A_W'(r_p);
                mul_b = {10'd0, w_sat};
            end
            ctf_pkg::OP_MULA: begin
                mul_a = ctf_pkg::MUL_A_W'(r_pa);
                mul_b = {10'd0, w_acc};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // CORDIC start vector with pre-rotation into the right half plane
    always_comb begin
        ld_x  = {{(XY_W-30){i_accel_z[15]}}, i_accel_z, 14'd0};
        ld_y  = {{(XY_W-30){i_accel_x[15]}}, i_accel_x, 14'd0};
        ld_xn = -ld_x;
        ld_yn = -ld_y;
        ld_xr = ld_x;
        ld_yr = ld_y;
        ld_z  = '0;
        if (ld_x[XY_W-1]) begin
            if (!ld_y[XY_W-1]) begin
                ld_xr = ld_y;
                ld_yr = ld_xn;
                ld_z  = ctf_pkg::PRE_ROT_ANGLE;
            end else begin
                ld_xr = ld_yn;
                ld_yr = ld_x;
                ld_z  = -ctf_pkg::PRE_ROT_ANGLE;
            end
        end
    end

    // One CORDIC micro-rotation
    assign cr_dx  = r_y >>> i_cmd.cordic_idx;
    assign cr_dy  = r_x >>> i_cmd.cordic_idx;
    assign cr_tab = ctf_pkg::atan_entry(i_cmd.cordic_idx);

    // Integration delta magnitude, pre-divided by 2^11
    assign sc_p   = r_prod[37:0];
    assign sc_mag = sc_p[37] ? 38'(-sc_p) : 38'(sc_p);
    assign sc_sum = sc_mag + ctf_pkg::DELTA_HALF;

    // Reciprocal quotient correction and sign restore
    assign fx_rem   = {1'b0, r_dv} - r_prod[25:0];
    assign fx_q     = r_q + 19'((fx_rem >= ctf_pkg::DIVISOR_125) ? 1'b1 : 1'b0);
    assign fx_delta = r_dneg ? -$signed({1'b0, fx_q}) : $signed({1'b0, fx_q});

    // Round the CORDIC angle to 1/128 degree and clamp
    always_comb begin
        an_r  = r_z + 25'sd128;
        an_s  = an_r >>> 8;
        an_pa = an_s[15:0];
        if (an_s > Z_W'(ctf_pkg::ANGLE_LIMIT)) begin
            an_pa = ctf_pkg::ANGLE_LIMIT[15:0];
        end else if (an_s < -Z_W'(ctf_pkg::ANGLE_LIMIT)) begin
            an_pa = -ctf_pkg::ANGLE_LIMIT[15:0];
        end
        if (r_zero) begin
            an_pa = '0;
        end
    end

    // Scale the blend sum back from Q16 and saturate
    always_comb begin
        st_s = r_sum >>> 16;
        st_b = st_s[15:0];
        if (st_s > 38'sd32767) begin
            st_b = 16'sh7fff;
        end else if (st_s < -38'sd32768) begin
            st_b = 16'sh8000;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_step) begin
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + cr_dx;
                r_y <= r_y - cr_dy;
                r_z <= r_z + cr_tab;
            end else begin
                r_x <= r_x - cr_dx;
                r_y <= r_y + cr_dy;
                r_z <= r_z - cr_tab;
            end
        end
        case (i_cmd.op)
            ctf_pkg::OP_LOAD: begin
                r_op   <= i_opcode;
                r_gy   <= i_gyro_y;
                r_gz   <= i_gyro_z;
                r_zero <= (i_accel_x == 16'd0) && (i_accel_z == 16'd0);
                r_x    <= ld_xr;
                r_y    <= ld_yr;
                r_z    <= ld_z;
            end
            ctf_pkg::OP_GYFS: begin
                r_prod <= mul_p;
            end
            ctf_pkg::OP_GZFS: begin
                r_gyfs  <= r_prod[26:0];
                r_pitch <= rate_round(r_prod[26:0]);
                r_prod  <= mul_p;
            end
            ctf_pkg::OP_STEP: begin
                r_yaw  <= rate_round(r_prod[26:0]);
                r_prod <= mul_p;
            end
            ctf_pkg::OP_SCALE: begin
                r_dneg <= sc_p[37];
                r_dv   <= sc_sum[35:11];
            end
            ctf_pkg::OP_RECIP: begin
                r_prod <= mul_p;
            end
            ctf_pkg::OP_QUOT: begin
                r_q <= r_prod[50:32];
            end
            ctf_pkg::OP_QMUL: begin
                r_prod <= mul_p;
            end
            ctf_pkg::OP_FIX: begin
                r_delta <= fx_delta;
            end
            ctf_pkg::OP_PSUB: begin
                r_p <= 20'(r_fused) - r_delta;
            end
            ctf_pkg::OP_ANGLE: begin
                r_pa <= an_pa;
            end
            ctf_pkg::OP_MULW: begin
                r_prod <= mul_p;
            end
            ctf_pkg::OP_MULA: begin
                r_acc  <= r_prod[36:0];
                r_prod <= mul_p;
            end
            ctf_pkg::OP_SUM: begin
                r_sum <= 38'(r_acc) + 38'($signed(r_prod[36:0])) + 38'sd32768;
            end
            ctf_pkg::OP_OUT: begin
                r_out_tilt  <= r_fused;
                r_out_pa    <= r_pa;
                r_out_pitch <= r_pitch;
                r_out_yaw   <= r_yaw;
            end
            default: begin
            end
        endcase
    end

    // Stored tilt and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == ctf_pkg::OP_STORE) begin
                r_fused <= r_op ? st_b : r_pa;
            end
            if (i_cmd.op == ctf_pkg::OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_ovalid || i_ready;
    assign o_valid        = r_ovalid;
    assign o_tilt_angle   = r_out_tilt;
    assign o_accel_angle  = r_out_pa;
    assign o_pitch_rate   = r_out_pitch;
    assign o_yaw_rate     = r_out_yaw;

endmodule

// ===== rtl/complementary_tilt_filter_top.sv =====
// Top level of the complementary tilt filter: stream ports, configuration registers, units.
// A new item is taken only in the idle state, once the previous result has gone into the
// output register; the CORDIC runs at one step per cycle beside the multiply chain. The
// result waits in the output register, so the next item is taken while it is pending.
// Reset: synchronous active low; stored tilt clears to zero, registers take their defaults.
module complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // accel_x[15:0], accel_z[31:16], gyro_y[47:32], gyro_z[63:48]
    input  logic        i_s_tuser,   // opcode[0]
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // tilt_angle[15:0], accel_angle[31:16],
                                     // pitch_rate[50:32], yaw_rate[69:51], zero[71:70]
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [16:0] i_cfg_data
);

    logic [16:0]       r_blend_weight;
    logic [10:0]       r_gyro_fs;
    logic [9:0]        r_step_ms;
    ctf_pkg::t_ctf_cmd cmd;
    ctf_pkg::t_ctf_sts sts;
    logic [15:0]       tilt_angle, accel_angle;
    logic [18:0]       pitch_rate, yaw_rate;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= 17'd62415;
            r_gyro_fs      <= 11'd250;
            r_step_ms      <= 10'd10;
        end else if (i_cfg_valid) begin
            case (ctf_pkg::t_cfg_idx'(i_cfg_addr))
                ctf_pkg::CFG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data;
                ctf_pkg::CFG_GYRO_FS:      r_gyro_fs      <= i_cfg_data[10:0];
                ctf_pkg::CFG_STEP_MS:      r_step_ms      <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    ctf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ctf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_s_tuser),
        .i_accel_x      (i_s_tdata[15:0]),
        .i_accel_z      (i_s_tdata[31:16]),
        .i_gyro_y       (i_s_tdata[47:32]),
        .i_gyro_z       (i_s_tdata[63:48]),
        .i_blend_weight (r_blend_weight),
        .i_gyro_fs      (r_gyro_fs),
        .i_step_ms      (r_step_ms),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_tilt_angle   (tilt_angle),
        .o_accel_angle  (accel_angle),
        .o_pitch_rate   (pitch_rate),
        .o_yaw_rate     (yaw_rate)
    );

    // Pack the result transaction
    assign o_m_tdata = {2'b00, yaw_rate, pitch_rate, accel_angle, tilt_angle};

endmodule

// ===== test/tb_complementary_tilt_filter_top.sv =====
// Self-checking testbench for the complementary tilt filter: stream stimulus, tilt predictor, checker.
module tb_complementary_tilt_filter_top;

    localparam int STEPS          = 16;
    localparam int ROT_STEPS      = (STEPS < 24) ? STEPS : 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 2 * (ROT_STEPS + 7);
    localparam int MAX_REPORTS    = 150;
    localparam int PHASE_ITEMS    = 240;

    localparam longint QUARTER_TURN_Q15 = 2949120;
    localparam longint ACCEL_ANGLE_MAX  = 23040;

    // Opcodes and the register index that selects no register
    localparam logic       OPC_INIT   = 1'b0;
    localparam logic       OPC_FUSE   = 1'b1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic        opc;
        logic [15:0] ax;
        logic [15:0] az;
        logic [15:0] gy;
        logic [15:0] gz;
    } t_imu_sample;

    typedef struct {
        logic signed [15:0] tilt;
        logic signed [15:0] accel_ang;
        logic signed [18:0] pitch;
        logic signed [18:0] yaw;
    } t_tilt_result;

    typedef enum logic {
        RX_STEADY,
        RX_CHOPPY
    } t_rx_mode;

    // Arctangent of 2^-i in 2^-15 degree
    longint atan_q15 [0:23] = '{
        1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0, 0
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata   = '0;
    logic        i_s_tuser   = OPC_INIT;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [71:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr  = ctf_pkg::CFG_BLEND_WEIGHT;
    logic [16:0] i_cfg_data  = '0;

    // Predictor copy of the registers and the stored tilt
    logic [16:0]        mdl_weight;
    logic [10:0]        mdl_fs;
    logic [9:0]         mdl_step;
    logic signed [15:0] mdl_tilt;
    t_tilt_result       pending_results [$];

    int n_errors    = 0;
    int n_reports   = 0;
    int n_samples   = 0;
    int n_inits     = 0;
    int n_results   = 0;
    int n_cfg       = 0;
    int idle_cycles = 0;

    // Stimulus pacing shared between the test tasks and the receiver
    bit       tx_bursty     = 1'b0;
    int       tx_burst_left = 0;
    t_rx_mode rx_mode       = RX_STEADY;
    int       hold_token    = 0;

    complementary_tilt_filter_top #(
        .CORDIC_STEPS(STEPS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Generate the clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Divide and round half away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Vectoring CORDIC: atan2(ay, ax) in 1/128 degree
    function automatic longint accel_tilt(input longint ay, input longint ax);
        longint x, y, z, t, dx, dy;
        if (ax == 0 && ay == 0)
            return 0;
        x = ax * 16384;
        y = ay * 16384;
        z = 0;
        // Rotate a left half plane vector by a quarter turn first
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = QUARTER_TURN_Q15;
            end else begin
                t = -y; y = x; x = t; z = -QUARTER_TURN_Q15;
            end
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_q15[i];
            end else begin
                x -= dx; y += dy; z -= atan_q15[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z > ACCEL_ANGLE_MAX)
            z = ACCEL_ANGLE_MAX;
        if (z < -ACCEL_ANGLE_MAX)
            z = -ACCEL_ANGLE_MAX;
        return z;
    endfunction

    // Predict one result and advance the stored tilt
    function automatic t_tilt_result fuse_sample(input t_imu_sample s);
        longint ax, az, gy, gz, fs, stp, w, pa, delta, p, b;
        t_tilt_result r;
        ax  = longint'($signed(s.ax));
        az  = longint'($signed(s.az));
        gy  = longint'($signed(s.gy));
        gz  = longint'($signed(s.gz));
        fs  = longint'(mdl_fs);
        stp = longint'(mdl_step);
        w   = (mdl_weight > ctf_pkg::WEIGHT_ONE) ? longint'(ctf_pkg::WEIGHT_ONE)
                                                 : longint'(mdl_weight);
        pa  = accel_tilt(ax, az);
        if (s.opc == OPC_INIT) begin
            mdl_tilt = 16'(pa);
        end else begin
            delta = round_div(gy * fs * stp, 256000);
            p     = longint'(mdl_tilt) - delta;
            b     = (w * p + (65536 - w) * pa + 32768) >>> 16;
            if (b > 32767)
                b = 32767;
            if (b < -32768)
                b = -32768;
            mdl_tilt = 16'(b);
        end
        r.tilt      = mdl_tilt;
        r.accel_ang = 16'(pa);
        r.pitch     = 19'(round_div(gy * fs, 256));
        r.yaw       = 19'(round_div(gz * fs, 256));
        return r;
    endfunction

    // Compare one output field and report a mismatch
    task automatic check_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            n_errors++;
            if (n_reports < MAX_REPORTS)
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            else if (n_reports == MAX_REPORTS)
                $display("%0t: further mismatches not shown", $time);
            n_reports++;
        end
    endtask

    // Track register writes and input transactions, check output transactions
    always @(posedge i_clk) begin : monitor
        t_imu_sample  smp;
        t_tilt_result want;
        if (!i_rst_n) begin
            mdl_weight = 17'd62415;
            mdl_fs     = 11'd250;
            mdl_step   = 10'd10;
            mdl_tilt   = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                case (i_cfg_addr)
                    ctf_pkg::CFG_BLEND_WEIGHT: mdl_weight = i_cfg_data;
                    ctf_pkg::CFG_GYRO_FS:      mdl_fs     = i_cfg_data[10:0];
                    ctf_pkg::CFG_STEP_MS:      mdl_step   = i_cfg_data[9:0];
                    default:                   ;
                endcase
            end
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, o_m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    check_field("tilt_angle", want.tilt, $signed(o_m_tdata[15:0]));
                    check_field("accel_angle", want.accel_ang, $signed(o_m_tdata[31:16]));
                    check_field("pitch_rate", want.pitch, $signed(o_m_tdata[50:32]));
                    check_field("yaw_rate", want.yaw, $signed(o_m_tdata[69:51]));
                    check_field("zero_pad", 0, o_m_tdata[71:70]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                smp.opc = i_s_tuser;
                smp.ax  = i_s_tdata[15:0];
                smp.az  = i_s_tdata[31:16];
                smp.gy  = i_s_tdata[47:32];
                smp.gz  = i_s_tdata[63:48];
                n_samples++;
                if (smp.opc == OPC_INIT)
                    n_inits++;
                pending_results.push_back(fuse_sample(smp));
            end
        end
    end

    // End the run when no transaction happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drive the output ready: long hold on request, else steady or choppy runs
    always @(negedge i_clk) begin : receiver
        static int  hold_seen   = 0;
        static int  hold_left   = 0;
        static int  rx_run_left = 0;
        static bit  rx_on       = 1'b0;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else if (rx_mode == RX_STEADY) begin
            i_m_tready = 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_on       = !rx_on;
                rx_run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run_left--;
            i_m_tready = rx_on;
        end
    end

    function automatic t_imu_sample make_sample(input logic opc, input int ax, input int az,
                                                input int gy, input int gz);
        t_imu_sample s;
        s.opc = opc;
        s.ax  = ax[15:0];
        s.az  = az[15:0];
        s.gy  = gy[15:0];
        s.gz  = gz[15:0];
        return s;
    endfunction

    // Offset a raw reading by a random amount within +/- spread, wrapping at 16 bits
    function automatic logic [15:0] jitter16(input logic [15:0] base, input int spread);
        int v;
        v = int'($signed(base)) + int'($urandom_range(0, 2 * spread)) - spread;
        return v[15:0];
    endfunction

    function automatic t_imu_sample noise_sample();
        t_imu_sample s;
        s.opc = 1'($urandom_range(0, 1));
        s.ax  = 16'($urandom);
        s.az  = 16'($urandom);
        s.gy  = 16'($urandom);
        s.gz  = 16'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            s.ax = '0;
            s.az = '0;
        end
        return s;
    endfunction

    // Offer one sample and hold it until the transaction; insert burst gaps
    task automatic send_sample(input t_imu_sample s);
        int gap;
        if (tx_bursty && tx_burst_left == 0) begin
            gap           = $urandom_range(1, 24);
            tx_burst_left = $urandom_range(1, 16);
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = s.opc;
        i_s_tdata  = {s.gz, s.gy, s.az, s.ax};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Accel angle corners with the reset register values
    task automatic test_accel_angles();
        tx_bursty = 1'b0;
        rx_mode   = RX_STEADY;
        send_sample(make_sample(OPC_INIT, 0, 0, 0, 0));
        send_sample(make_sample(OPC_INIT, 0, -1, 1, -1));
        send_sample(make_sample(OPC_INIT, 0, -32768, -32768, -32768));
        send_sample(make_sample(OPC_INIT, 32767, 0, 32767, 32767));
        send_sample(make_sample(OPC_INIT, -32768, 0, -1, 1));
        send_sample(make_sample(OPC_INIT, -32768, -32768, 128, -128));
        send_sample(make_sample(OPC_INIT, 32767, 32767, 0, 0));
        send_sample(make_sample(OPC_FUSE, 1, -1, 50, -50));
        send_sample(make_sample(OPC_FUSE, -1, -1, -3, 3));
        send_sample(make_sample(OPC_FUSE, 100, 16384, 500, -500));
        send_sample(make_sample(OPC_FUSE, 0, 0, -32768, 32767));
        send_sample(make_sample(OPC_FUSE, -32768, 32767, 1, 0));
        wait_idle();
    endtask

    // Register extremes: tilt saturation, weight above one, zero rate scale and step
    task automatic test_register_corners();
        write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'd65536);
        write_reg(ctf_pkg::CFG_GYRO_FS, 17'd2000);
        write_reg(ctf_pkg::CFG_STEP_MS, 17'd1000);
        send_sample(make_sample(OPC_INIT, 32767, 0, 0, 0));
        send_sample(make_sample(OPC_FUSE, 32767, 0, -32768, 100));
        send_sample(make_sample(OPC_FUSE, 32767, 0, 32767, -100));
        send_sample(make_sample(OPC_FUSE, -32768, 1, 32767, 0));
        wait_idle();
        write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'd131071);
        write_reg(ctf_pkg::CFG_GYRO_FS, 17'd2047);
        write_reg(ctf_pkg::CFG_STEP_MS, 17'd1023);
        send_sample(make_sample(OPC_FUSE, 5, 5, -32768, 32767));
        wait_idle();
        write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'd0);
        send_sample(make_sample(OPC_FUSE, -5, 7, 32767, -32768));
        wait_idle();
        write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'd65537);
        write_reg(ctf_pkg::CFG_GYRO_FS, 17'd0);
        send_sample(make_sample(OPC_FUSE, 300, -4000, 32767, 32767));
        wait_idle();
        write_reg(ctf_pkg::CFG_GYRO_FS, 17'd1);
        write_reg(ctf_pkg::CFG_STEP_MS, 17'd0);
        send_sample(make_sample(OPC_FUSE, -300, -4000, -32768, -32768));
        wait_idle();
        write_reg(ctf_pkg::CFG_STEP_MS, 17'd1);
        write_reg(CFG_UNUSED, 17'h1FFFF);
        send_sample(make_sample(OPC_FUSE, 1000, 2000, -32768, 255));
        wait_idle();
        write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'd62415);
        write_reg(ctf_pkg::CFG_GYRO_FS, 17'd250);
        write_reg(ctf_pkg::CFG_STEP_MS, 17'd10);
        send_sample(make_sample(OPC_FUSE, 1000, 2000, 700, -700));
        wait_idle();
    endtask

    // Random settings; mostly init-then-track sequences, some noise
    task automatic test_random_fusion(input int n_phases);
        t_imu_sample s;
        logic [15:0] base_x, base_z;
        int sent, run, gy_spread;
        for (int ph = 0; ph < n_phases; ph++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'($urandom_range(65537, 131071)));
                1:       write_reg(ctf_pkg::CFG_BLEND_WEIGHT,
                                   $urandom_range(0, 1) ? 17'd65536 : 17'd0);
                default: write_reg(ctf_pkg::CFG_BLEND_WEIGHT, 17'($urandom_range(0, 65536)));
            endcase
            write_reg(ctf_pkg::CFG_GYRO_FS, 17'($urandom_range(0, 2047)));
            write_reg(ctf_pkg::CFG_STEP_MS, 17'($urandom_range(0, 1023)));
            // Leave the last phase free of idling on both sides
            tx_bursty = (ph != n_phases - 1);
            rx_mode   = (ph != n_phases - 1) ? RX_CHOPPY : RX_STEADY;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_sample(noise_sample());
                    sent++;
                end else begin
                    base_x    = 16'($urandom);
                    base_z    = 16'($urandom);
                    run       = $urandom_range(4, 30);
                    gy_spread = $urandom_range(0, 1) ? 32767 : 2000;
                    s = make_sample(OPC_INIT, base_x, base_z, $urandom, $urandom);
                    send_sample(s);
                    sent++;
                    for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
                        s.opc = OPC_FUSE;
                        s.ax  = jitter16(base_x, 256);
                        s.az  = jitter16(base_z, 256);
                        s.gy  = jitter16(16'd0, gy_spread);
                        s.gz  = 16'($urandom);
                        send_sample(s);
                        sent++;
                    end
                end
            end
        end
    endtask

    // Hold the output off long enough to stall the input, then drain fully
    task automatic test_output_backpressure();
        wait_idle();
        tx_bursty = 1'b0;
        rx_mode   = RX_STEADY;
        hold_token++;
        repeat (40) send_sample(noise_sample());
        rx_mode = RX_CHOPPY;
        wait_idle();
        tx_bursty = 1'b1;
        repeat (20) send_sample(noise_sample());
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_accel_angles();
        test_register_corners();
        test_random_fusion(5);
        test_output_backpressure();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        $display("Covered %0d samples (%0d tilt loads, %0d fused updates), %0d register writes,",
                 n_samples, n_inits, n_samples - n_inits, n_cfg);
        $display("%0d results checked, with burst gaps, output stalls and one long hold.",
                 n_results);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
